### hdl/fifo_queue_with_remove_by_id_defines.svh
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_by_id_defines
// assertion macros shared by the queue checker
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_REMOVE_BY_ID_DEFINES_SVH
`define FIFO_QUEUE_WITH_REMOVE_BY_ID_DEFINES_SVH

// condition implies consequence in the same cycle
`define FQR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("queue check failed");

// condition implies consequence in the next cycle
`define FQR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("queue check failed");

`endif

### hdl/fqr_pkg.sv
// ----------------------------------------------------------------------------
// fqr_pkg
// shared codes, defaults and cell control type for the id queue
// ----------------------------------------------------------------------------
package fqr_pkg;

  localparam int DEFAULT_DEPTH    = 16;
  localparam int DEFAULT_ID_WIDTH = 16;

  // operation codes
  localparam logic [1:0] OP_ENQ = 2'd0;
  localparam logic [1:0] OP_DEQ = 2'd1;
  localparam logic [1:0] OP_REM = 2'd2;
  localparam logic [1:0] OP_HAS = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // per-cell control from the queue controller
  typedef struct packed {
    logic occupied;   // cell lies below the fill count
    logic head_pick;  // dequeue: head cell counts as the hit
    logic match_en;   // remove or contains: compare against key
    logic close_en;   // cells at or behind the hit take the neighbor's id
    logic load;       // enqueue lands in this cell
  } fqr_cell_ctrl_t;

endpackage

### hdl/fqr_cell.sv
// ----------------------------------------------------------------------------
// fqr_cell
// one queue slot: holds an id, compares it, and closes up from its neighbor
// ----------------------------------------------------------------------------
module fqr_cell #(
  parameter int ID_WIDTH = fqr_pkg::DEFAULT_ID_WIDTH
) (
  input  logic                   clk,
  input  fqr_pkg::fqr_cell_ctrl_t ctrl,
  input  logic [ID_WIDTH-1:0]    key,
  input  logic [ID_WIDTH-1:0]    nb_id,
  input  logic                   seen_in,
  input  logic [ID_WIDTH-1:0]    take_in,
  output logic                   seen_out,
  output logic [ID_WIDTH-1:0]    take_out,
  output logic [ID_WIDTH-1:0]    id
);
  import fqr_pkg::*;

  logic hit;
  logic first;

  // hit detection and oldest-match priority along the chain
  assign hit      = ctrl.occupied & (ctrl.head_pick | (ctrl.match_en & (id == key)));
  assign first    = hit & ~seen_in;
  assign seen_out = seen_in | hit;
  assign take_out = take_in | (first ? id : '0);

  // slot storage: enqueue load or close-up shift
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      id <= key;
    end else if (ctrl.close_en & seen_out) begin
      id <= nb_id;
    end
  end

endmodule

### hdl/fifo_queue_with_remove_by_id.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_by_id
// fifo ready queue of ids with dequeue, remove-by-id and contains query
// ----------------------------------------------------------------------------
//  channel  | signals                                    | direction
//  ---------+--------------------------------------------+----------
//  in       | in_valid, in_stall, operation, entry_id    | to block
//  out      | out_valid, out_stall, status, result_id,   | from block
//           | found, empty_flag, occupancy               |
//
//  one item per cycle while no result is stalled; the result appears in the cycle after the item is taken.
//  each operation is settled in a single pass along the row of cells: every
//  cell compares in parallel and a one-bit priority chain picks the oldest hit.
//  reset empties the queue (fill count zero) and drops any pending result.
//  in_stall is raised only while a result sits in the output register and
//  out_stall holds it there.
// ----------------------------------------------------------------------------
module fifo_queue_with_remove_by_id #(
  parameter int DEPTH    = fqr_pkg::DEFAULT_DEPTH,
  parameter int ID_WIDTH = fqr_pkg::DEFAULT_ID_WIDTH,
  localparam int CW      = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          operation,
  input  logic [ID_WIDTH-1:0] entry_id,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [ID_WIDTH-1:0] result_id,
  output logic                found,
  output logic                empty_flag,
  output logic [CW-1:0]       occupancy
);
  import fqr_pkg::*;

  logic                 accept;
  logic [CW-1:0]        fill_count;
  logic [CW-1:0]        fill_count_next;
  logic                 is_full;
  logic                 is_empty;
  logic                 op_enq;
  logic                 op_deq;
  logic                 op_rem;
  logic                 op_has;
  fqr_cell_ctrl_t       ctrl [DEPTH];
  logic [ID_WIDTH-1:0]  cell_id [DEPTH];
  logic [DEPTH:0]       seen;
  logic [ID_WIDTH-1:0]  take [DEPTH+1];
  logic                 hit_any;
  logic [1:0]           status_next;
  logic [ID_WIDTH-1:0]  rid_next;
  logic                 found_next;

  // handshake
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // decode
  assign op_enq   = (operation == OP_ENQ);
  assign op_deq   = (operation == OP_DEQ);
  assign op_rem   = (operation == OP_REM);
  assign op_has   = (operation == OP_HAS);
  assign is_full  = (fill_count == CW'(DEPTH));
  assign is_empty = (fill_count == '0);

  // per-cell control
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i].occupied  = (CW'(i) < fill_count);
      ctrl[i].head_pick = op_deq & (i == 0);
      ctrl[i].match_en  = op_rem | op_has;
      ctrl[i].close_en  = accept & (op_deq | op_rem) & ~is_empty;
      ctrl[i].load      = accept & op_enq & ~is_full & (fill_count == CW'(i));
    end
  end

  // row of cells
  assign seen[0] = 1'b0;
  assign take[0] = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ID_WIDTH-1:0] nb;
    if (g == DEPTH - 1) begin : g_last
      assign nb = '0;
    end else begin : g_mid
      assign nb = cell_id[g+1];
    end
    fqr_cell #(
      .ID_WIDTH (ID_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl[g]),
      .key      (entry_id),
      .nb_id    (nb),
      .seen_in  (seen[g]),
      .take_in  (take[g]),
      .seen_out (seen[g+1]),
      .take_out (take[g+1]),
      .id       (cell_id[g])
    );
  end

  assign hit_any = seen[DEPTH];

  // result and fill count
  always_comb begin
    status_next     = ST_OK;
    rid_next        = '0;
    found_next      = 1'b0;
    fill_count_next = fill_count;
    if (op_enq) begin
      if (is_full) begin
        status_next = ST_FULL;
      end else begin
        fill_count_next = fill_count + CW'(1);
      end
    end else if (is_empty) begin
      status_next = ST_EMPTY;
    end else if (!hit_any) begin
      status_next = ST_NOT_FOUND;
    end else begin
      found_next = ~op_deq;
      if (!op_has) begin
        rid_next        = take[DEPTH];
        fill_count_next = fill_count - CW'(1);
      end
    end
  end

  // fill count register
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept) begin
      fill_count <= fill_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= accept | (out_valid & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= status_next;
      result_id  <= rid_next;
      found      <= found_next;
      empty_flag <= (fill_count_next == '0);
      occupancy  <= fill_count_next;
    end
  end

endmodule

### hdl/fqr_checker.sv
// ----------------------------------------------------------------------------
// fqr_checker
// port-level checks on the id queue, bound to the top level
// ----------------------------------------------------------------------------
`include "fifo_queue_with_remove_by_id_defines.svh"

module fqr_checker #(
  parameter int DEPTH    = fqr_pkg::DEFAULT_DEPTH,
  localparam int CW      = $clog2(DEPTH + 1)
) (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [1:0]          status,
  input logic                found,
  input logic                empty_flag,
  input logic [CW-1:0]       occupancy
);
  import fqr_pkg::*;

  // a stalled result stays put
  `FQR_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid)

  // input is held off only by a waiting result
  `FQR_ASSERT_NOW(a_stall_cause, clk, rst, in_stall, out_valid && out_stall)

  // empty flag agrees with occupancy
  `FQR_ASSERT_NOW(a_empty, clk, rst, out_valid, empty_flag == (occupancy == '0))

  // full status only at capacity
  `FQR_ASSERT_NOW(a_full, clk, rst, out_valid && status == ST_FULL, occupancy == CW'(DEPTH))

  // a match always reports ok
  `FQR_ASSERT_NOW(a_found, clk, rst, out_valid && found, status == ST_OK)

endmodule

bind fifo_queue_with_remove_by_id fqr_checker #(
  .DEPTH    (DEPTH)
) u_fqr_checker (.*);
